>>> hdl/des_pkg.sv
`default_nettype none

package des_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int DIR_BIT_POS  = 4;
    localparam int KEY_W        = 1 + 64 + 24;
    localparam int REMAINING_W  = 7;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] file_time;
        logic [15:0] file_date;
        logic [31:0] file_size;
        logic [23:0] name_ext;
        logic [63:0] name_main;
        logic [7:0]  attributes;
    } record_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic take;
    } cell_cmd_t;

    // smaller key leaves first: directories ahead, then name bytes
    function automatic logic [KEY_W-1:0] rank_key(input record_t rec);
        rank_key = {~rec.attributes[DIR_BIT_POS], rec.name_main, rec.name_ext};
    endfunction

    function automatic logic [7:0] lower_char(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            lower_char = c + CASE_OFFSET;
        end else begin
            lower_char = c;
        end
    endfunction

    function automatic record_t fold_case(input record_t rec);
        record_t r;
        r = rec;
        if (!rec.attributes[DIR_BIT_POS]) begin
            for (int k = 0; k < 8; k++) begin
                r.name_main[8*k +: 8] = lower_char(rec.name_main[8*k +: 8]);
            end
            for (int k = 0; k < 3; k++) begin
                r.name_ext[8*k +: 8] = lower_char(rec.name_ext[8*k +: 8]);
            end
        end
        fold_case = r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/des_cell.sv
`default_nettype none

module des_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  des_pkg::cell_cmd_t   cmd,
    input  des_pkg::record_t     new_rec,
    input  wire                  prev_before,
    input  des_pkg::record_t     prev_rec,
    input  wire                  prev_valid,
    input  des_pkg::record_t     next_rec,
    input  wire                  next_valid,
    output logic                 ahead,
    output des_pkg::record_t     rec,
    output logic                 valid
);
    import des_pkg::*;

    record_t rec_reg, rec_next;
    logic    valid_reg, valid_next;

    // new record ranks ahead of what this cell holds; ties stay behind
    assign ahead = !valid_reg || (rank_key(new_rec) < rank_key(rec_reg));

    always_comb begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (cmd.insert && ahead) begin
            if (prev_before) begin
                rec_next   = prev_rec;
                valid_next = prev_valid;
            end else begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end else if (cmd.take) begin
            rec_next   = next_rec;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

>>> hdl/directory_entry_sorter.sv
// directory entry sorter
// requests arrive on the s_ channel: s_tuser is the operation (0 insert,
// 1 take), s_tdata the record. results leave on the m_ channel: m_tuser is
// the status (0 ok, 1 full and record dropped, 2 empty), m_tdata the taken
// record (zero for inserts and failed takes) and the count left behind.
// records sit in a sorted row of CAPACITY cells, least at the head. an
// insert is compared against every cell at once and each cell either keeps
// its record, takes the new one or takes its left neighbor's; a take reads
// the head and every cell takes its right neighbor's record.
// each request updates the cell row when it is accepted, and its result is in
// the output register in the cycle after acceptance. the single output register
// limits throughput to one request per cycle while m_tready stays high;
// when the receiver stalls, s_tready drops until the result is taken.
// reset empties the store at once; no clearing pass is needed.
`default_nettype none

module directory_entry_sorter #(
    parameter int CAPACITY = des_pkg::DEFAULT_CAPACITY
) (
    input  wire          aclk,
    input  wire          aresetn,
    // s_tuser: operation
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [0:0]   s_tuser,
    // s_tdata: attributes, name_main, name_ext, file_size, file_date, file_time
    input  wire  [159:0] s_tdata,
    // m_tuser: status
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [1:0]   m_tuser,
    // m_tdata: out_attributes, out_name_main, out_name_ext, out_size, out_date,
    // out_time, remaining, zero pad
    output logic [167:0] m_tdata
);
    import des_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg, status_next;
    record_t          out_rec_reg, out_rec_next;
    logic [REMAINING_W-1:0] remaining_reg, remaining_next;

    cell_cmd_t cmd;
    record_t   in_rec;
    record_t   new_rec;
    logic      accept;

    record_t cell_rec   [CAPACITY];
    logic    cell_valid [CAPACITY];
    logic    cell_before[CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_rec  = record_t'(s_tdata);
    assign new_rec = fold_case(in_rec);

    always_comb begin
        cmd.insert     = 1'b0;
        cmd.take       = 1'b0;
        count_next     = count_reg;
        status_next    = status_reg;
        out_rec_next   = out_rec_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = STATUS_OK;
            out_rec_next = '0;
            if (s_tuser[0] == OP_INSERT) begin
                if (count_reg == CAP_CNT) begin
                    status_next = STATUS_FULL;
                end else begin
                    cmd.insert = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (count_reg == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    cmd.take     = 1'b1;
                    out_rec_next = cell_rec[0];
                    count_next   = count_reg - 1'b1;
                end
            end
        end
        remaining_next = accept ? REMAINING_W'(count_next) : remaining_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic    p_before;
        record_t p_rec;
        logic    p_valid;
        record_t n_rec;
        logic    n_valid;

        if (i == 0) begin : g_head
            assign p_before = 1'b0;
            assign p_rec    = new_rec;
            assign p_valid  = 1'b0;
        end else begin : g_body
            assign p_before = cell_before[i-1];
            assign p_rec    = cell_rec[i-1];
            assign p_valid  = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign n_rec   = cell_rec[i];
            assign n_valid = 1'b0;
        end else begin : g_mid
            assign n_rec   = cell_rec[i+1];
            assign n_valid = cell_valid[i+1];
        end

        des_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .new_rec     (new_rec),
            .prev_before (p_before),
            .prev_rec    (p_rec),
            .prev_valid  (p_valid),
            .next_rec    (n_rec),
            .next_valid  (n_valid),
            .ahead       (cell_before[i]),
            .rec         (cell_rec[i]),
            .valid       (cell_valid[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg    <= status_next;
        out_rec_reg   <= out_rec_next;
        remaining_reg <= remaining_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, remaining_reg, out_rec_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("record count above capacity");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[0] == (count_reg != '0))
        else $error("head cell occupancy disagrees with count");

    a_tail_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[CAPACITY-1] == (count_reg == CAP_CNT))
        else $error("tail cell occupancy disagrees with count");

    a_take_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> count_reg == $past(count_reg) - 1'b1)
        else $error("take did not lower the count");

endmodule

`default_nettype wire

>>> verif/directory_entry_sorter_tb.sv
`timescale 1ns / 1ps

module directory_entry_sorter_tb;
    import des_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 6;

    typedef struct {
        logic [1:0]             status;
        record_t                rec;
        logic [REMAINING_W-1:0] remaining;
    } sort_result_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [0:0]     s_tuser  = OP_INSERT;
    // attributes, name_main, name_ext, file_size, file_date, file_time
    logic [159:0]   s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // status
    logic [1:0]     m_tuser;
    // out_attributes, out_name_main, out_name_ext, out_size, out_date, out_time,
    // remaining, zero pad
    logic [167:0]   m_tdata;

    record_t        held_records[$];
    sort_result_t   expected_results[$];
    logic [87:0]    name_pool[POOL_SIZE];
    logic           no_gaps = 1'b0;
    int             mismatches = 0;
    int             cycle_count = 0;

    directory_entry_sorter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic record_t fold_name_case(input record_t rec);
        record_t     r;
        logic [87:0] name;
        logic [7:0]  ch;
        r = rec;
        if (!rec.attributes[DIR_BIT_POS]) begin
            name = {rec.name_main, rec.name_ext};
            for (int k = 0; k < 11; k++) begin
                ch = name[8*k +: 8];
                if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                    name[8*k +: 8] = ch + CASE_OFFSET;
                end
            end
            {r.name_main, r.name_ext} = name;
        end
        return r;
    endfunction

    // strict order, so the earliest of equal records wins
    function automatic bit ranks_ahead(input record_t a, input record_t b);
        if (a.attributes[DIR_BIT_POS] != b.attributes[DIR_BIT_POS]) begin
            return a.attributes[DIR_BIT_POS];
        end
        if (a.name_main != b.name_main) begin
            return a.name_main < b.name_main;
        end
        return a.name_ext < b.name_ext;
    endfunction

    function automatic void predict_request(input logic op, input record_t rec);
        sort_result_t res;
        int           best;
        res.status = STATUS_OK;
        res.rec    = '0;
        if (op == OP_INSERT) begin
            if (held_records.size() >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                held_records.push_back(fold_name_case(rec));
            end
        end else if (held_records.size() == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < held_records.size(); i++) begin
                if (ranks_ahead(held_records[i], held_records[best])) begin
                    best = i;
                end
            end
            res.rec = held_records[best];
            held_records.delete(best);
        end
        res.remaining = REMAINING_W'(held_records.size());
        expected_results.push_back(res);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, want, got);
        end
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            report_mismatch(what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        sort_result_t want;
        record_t      got;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, 64'(m_tuser));
            end else begin
                want = expected_results.pop_front();
                got  = record_t'(m_tdata[159:0]);
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("out_attributes", 64'(want.rec.attributes),
                            64'(got.attributes));
                check_field("out_name_main", want.rec.name_main, got.name_main);
                check_field("out_name_ext", 64'(want.rec.name_ext), 64'(got.name_ext));
                check_field("out_size", 64'(want.rec.file_size), 64'(got.file_size));
                check_field("out_date", 64'(want.rec.file_date), 64'(got.file_date));
                check_field("out_time", 64'(want.rec.file_time), 64'(got.file_time));
                check_field("remaining", 64'(want.remaining), 64'(m_tdata[166:160]));
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int draw_idle();
        if (no_gaps || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic op, input record_t rec);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rec;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(op, rec);
        @(negedge aclk);
    endtask

    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ---------------------------------------------------------------- records

    function automatic record_t make_record(input logic [7:0] attr, input logic [63:0] base,
                                            input logic [23:0] ext, input logic [31:0] size,
                                            input logic [15:0] day, input logic [15:0] tod);
        record_t rec;
        rec.attributes = attr;
        rec.name_main  = base;
        rec.name_ext   = ext;
        rec.file_size  = size;
        rec.file_date  = day;
        rec.file_time  = tod;
        return rec;
    endfunction

    // letters of both cases, bytes at and around the edges of 'A'..'Z' and 'a'..'z', blanks and raw bytes
    function automatic logic [7:0] name_byte();
        logic [7:0] boundary[6] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B};
        case ($urandom_range(0, 4))
            0: begin
                return CHAR_UPPER_A + 8'($urandom_range(0, 25));
            end
            1: begin
                return 8'h61 + 8'($urandom_range(0, 25));
            end
            2: begin
                return boundary[$urandom_range(0, 5)];
            end
            3: begin
                return 8'h20;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    function automatic record_t random_record();
        record_t     rec;
        logic [87:0] name;
        for (int k = 0; k < 11; k++) begin
            name[8*k +: 8] = name_byte();
        end
        // reuse a pooled name with random case so ties show up often
        if ($urandom_range(0, 2) == 0) begin
            name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
            for (int k = 0; k < 11; k++) begin
                if (name[8*k +: 8] >= 8'h61 && name[8*k +: 8] <= 8'h7A &&
                    $urandom_range(0, 1) == 1) begin
                    name[8*k +: 8] = name[8*k +: 8] - CASE_OFFSET;
                end
            end
        end
        rec.attributes = 8'($urandom);
        {rec.name_main, rec.name_ext} = name;
        rec.file_size  = $urandom;
        rec.file_date  = 16'($urandom);
        rec.file_time  = 16'($urandom);
        return rec;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_take_from_empty();
        send_request(OP_TAKE, '1);
        send_request(OP_TAKE, random_record());
    endtask

    task automatic test_case_folding();
        // attribute byte 'A' must stay as it is
        send_request(OP_INSERT, make_record(8'h41, "ABCXYZ@[", "A`Z", 32'h1, 16'h2, 16'h3));
        send_request(OP_INSERT, make_record(8'h10, "ZEBRA   ", "TXT", 32'h4, 16'h5, 16'h6));
        send_request(OP_INSERT, make_record(8'hFF, '1, '1, '1, '1, '1));
        send_request(OP_INSERT, make_record(8'hEF, '1, '1, '1, '1, '1));
        send_request(OP_INSERT, make_record(8'h00, '0, '0, '0, '0, '0));
        repeat (5) send_request(OP_TAKE, random_record());
    endtask

    task automatic test_ordering_and_ties();
        send_request(OP_INSERT, make_record(8'h01, "README  ", "TXT", 32'd1, 16'd1, 16'd1));
        send_request(OP_INSERT, make_record(8'h20, "readme  ", "txt", 32'd2, 16'd2, 16'd2));
        send_request(OP_INSERT, make_record(8'h10, "readme  ", "txt", 32'd3, 16'd3, 16'd3));
        send_request(OP_INSERT, make_record(8'h00, "readme  ", "txu", 32'd4, 16'd4, 16'd4));
        // high bit of the first byte must compare as unsigned
        send_request(OP_INSERT, make_record(8'h00, 64'h8020202020202020, "   ",
                                            32'd5, 16'd5, 16'd5));
        send_request(OP_INSERT, make_record(8'h00, 64'h7F20202020202020, "   ",
                                            32'd6, 16'd6, 16'd6));
        repeat (7) send_request(OP_TAKE, random_record());
    endtask

    // phases vary the insert share, pushing toward filling past capacity and draining past empty
    task automatic test_random_traffic();
        int insert_pct[10] = '{95, 10, 50, 95, 70, 5, 30, 95, 50, 10};
        int sent;
        int run_len;
        int phase;
        sent  = 0;
        phase = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            for (int k = 0; k < 11; k++) begin
                name_pool[i][8*k +: 8] = name_byte();
            end
        end
        while (sent < 600) begin
            run_len = $urandom_range(70, 100);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                if ($urandom_range(1, 100) <= insert_pct[phase % 10]) begin
                    send_request(OP_INSERT, random_record());
                end else begin
                    send_request(OP_TAKE, random_record());
                end
            end
            sent += run_len;
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_take_from_empty();
        test_case_folding();
        test_ordering_and_ties();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
